/* sv/vpp_pkg.sv */
// Package for the vertex perspective projection pipeline.
// Holds widths, register codes, the configuration struct and the pixel clamp.
// No dependencies.
`default_nettype none
package vpp_pkg;

  localparam int CW    = 16;  // model coordinate
  localparam int CFG_DW = 16; // config write data
  localparam int CFG_IW = 4;  // config index
  localparam int SZW   = 11;  // viewport size
  localparam int PXW   = 10;  // pixel field
  localparam int SW    = 33;  // scaled coordinate
  localparam int PW    = 50;  // rotation product
  localparam int RW    = 36;  // rotated / translated coordinate, w
  localparam int XCW   = 53;  // clip coordinate
  localparam int BW    = 47;  // clamped numerator, 2W
  localparam int NW    = 58;  // dividend, aspect products
  localparam int QW    = 11;  // quotient bits = divider stages
  localparam int ROT_SH = 14; // Q2.14 trig
  localparam int DOF_SH = 8;  // depth offset to scaled format
  localparam int PRJ_SH = 12; // Q4.12 projection

  localparam int XF_ST = 4;
  localparam int CL_ST = 3;
  localparam int NS    = XF_ST + CL_ST + QW + 1;

  localparam logic [CFG_IW-1:0] REG_COS    = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_SIN    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_SCALE  = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_DOFF   = CFG_IW'(3);
  localparam logic [CFG_IW-1:0] REG_XPS    = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] REG_YPS    = CFG_IW'(5);
  localparam logic [CFG_IW-1:0] REG_WIDTH  = CFG_IW'(6);
  localparam logic [CFG_IW-1:0] REG_HEIGHT = CFG_IW'(7);

  typedef struct packed {
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic [15:0]        object_scale;
    logic signed [15:0] depth_offset;
    logic [15:0]        x_proj_scale;
    logic [15:0]        y_proj_scale;
    logic [SZW-1:0]     screen_width;
    logic [SZW-1:0]     screen_height;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    cos_theta:     16'sd16384,
    sin_theta:     16'sd0,
    object_scale:  16'd1280,
    depth_offset:  -16'sd6400,
    x_proj_scale:  16'd5321,
    y_proj_scale:  16'd7094,
    screen_width:  11'd320,
    screen_height: 11'd240
  };

  // min(size-1, q, 1023); zero size gives zero
  function automatic logic [PXW-1:0] pix_sat(input logic [QW-1:0] q,
                                             input logic [SZW-1:0] size);
    logic [SZW-1:0] lim;
    logic [SZW-1:0] m;
    lim = size - SZW'(1);
    m = (SZW'(q) > lim) ? lim : SZW'(q);
    if (size == '0) begin
      pix_sat = '0;
    end else if (m > SZW'({PXW{1'b1}})) begin
      pix_sat = {PXW{1'b1}};
    end else begin
      pix_sat = m[PXW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* sv/vpp_in_if.sv */
// Vertex request channel.
// Depends on vpp_pkg.
`default_nettype none
interface vpp_in_if;
  import vpp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] model_x;
  logic signed [CW-1:0] model_y;
  logic signed [CW-1:0] model_z;
  modport source (output valid, model_x, model_y, model_z, input ready);
  modport sink   (input valid, model_x, model_y, model_z, output ready);
endinterface
`default_nettype wire

/* sv/vpp_out_if.sv */
// Pixel result channel.
// Depends on vpp_pkg.
`default_nettype none
interface vpp_out_if;
  import vpp_pkg::*;
  logic           valid;
  logic           ready;
  logic [PXW-1:0] screen_x;
  logic [PXW-1:0] screen_y;
  logic           on_screen;
  logic           behind_camera;
  modport source (output valid, screen_x, screen_y, on_screen, behind_camera,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, on_screen, behind_camera,
                  output ready);
endinterface
`default_nettype wire

/* sv/vpp_cfg_if.sv */
// Configuration write channel.
// Depends on vpp_pkg.
`default_nettype none
interface vpp_cfg_if;
  import vpp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/vpp_xform.sv */
// Model transform: scale, Y rotation, depth offset, projection multiply.
// Four register stages. Depends on vpp_pkg.
`default_nettype none
module vpp_xform (
  input  wire logic                           clk,
  input  wire logic [vpp_pkg::XF_ST-1:0]      en,
  input  wire vpp_pkg::cfg_t                  cfg,
  input  wire logic signed [vpp_pkg::CW-1:0]  x,
  input  wire logic signed [vpp_pkg::CW-1:0]  y,
  input  wire logic signed [vpp_pkg::CW-1:0]  z,
  output logic signed [vpp_pkg::XCW-1:0]      xc,
  output logic signed [vpp_pkg::XCW-1:0]      yc,
  output logic signed [vpp_pkg::RW-1:0]       w
);
  import vpp_pkg::*;

  // stage 0: scale
  logic signed [SW-1:0] scl_e;
  logic signed [SW-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  // stage 1: rotation products
  logic signed [PW-1:0] cos_e, sin_e, sxe, sze;
  logic signed [PW-1:0] pxc_nxt, pzs_nxt, pxs_nxt, pzc_nxt;
  logic signed [PW-1:0] pxc_r, pzs_r, pxs_r, pzc_r;
  logic signed [SW-1:0] sy1_r;
  // stage 2: sums, floor shift, translate
  logic signed [PW-1:0] xsum, zsum;
  logic signed [RW-1:0] xr_nxt, zr, w_nxt;
  logic signed [RW-1:0] xr_r, w2_r;
  logic signed [SW-1:0] sy2_r;
  // stage 3: projection multiply
  logic signed [XCW-1:0] xps_e, yps_e;
  logic signed [XCW-1:0] xc_nxt, yc_nxt;
  logic signed [RW-1:0]  w3_r;

  assign scl_e  = SW'($signed({1'b0, cfg.object_scale}));
  assign sx_nxt = SW'(x) * scl_e;
  assign sy_nxt = SW'(y) * scl_e;
  assign sz_nxt = SW'(z) * scl_e;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sz_r <= sz_nxt;
    end
  end

  assign cos_e   = PW'(cfg.cos_theta);
  assign sin_e   = PW'(cfg.sin_theta);
  assign sxe     = PW'(sx_r);
  assign sze     = PW'(sz_r);
  assign pxc_nxt = sxe * cos_e;
  assign pzs_nxt = sze * sin_e;
  assign pxs_nxt = sxe * sin_e;
  assign pzc_nxt = sze * cos_e;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pxc_r <= pxc_nxt;
      pzs_r <= pzs_nxt;
      pxs_r <= pxs_nxt;
      pzc_r <= pzc_nxt;
      sy1_r <= sy_r;
    end
  end

  assign xsum   = pxc_r - pzs_r;
  assign zsum   = pxs_r + pzc_r;
  assign xr_nxt = xsum[RW+ROT_SH-1:ROT_SH];
  assign zr     = zsum[RW+ROT_SH-1:ROT_SH];
  assign w_nxt  = -(zr + (RW'(cfg.depth_offset) <<< DOF_SH));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      xr_r  <= xr_nxt;
      w2_r  <= w_nxt;
      sy2_r <= sy1_r;
    end
  end

  assign xps_e  = XCW'($signed({1'b0, cfg.x_proj_scale}));
  assign yps_e  = XCW'($signed({1'b0, cfg.y_proj_scale}));
  assign xc_nxt = XCW'(xr_r) * xps_e;
  assign yc_nxt = XCW'(sy2_r) * yps_e;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xc   <= xc_nxt;
      yc   <= yc_nxt;
      w3_r <= w2_r;
    end
  end

  assign w = w3_r;

endmodule
`default_nettype wire

/* sv/vpp_clip.sv */
// Clip-space clamp, pixel numerators and aspect test.
// Three register stages. Depends on vpp_pkg.
`default_nettype none
module vpp_clip (
  input  wire logic                            clk,
  input  wire logic [vpp_pkg::CL_ST-1:0]       en,
  input  wire logic [vpp_pkg::SZW-1:0]         width,
  input  wire logic [vpp_pkg::SZW-1:0]         height,
  input  wire logic signed [vpp_pkg::XCW-1:0]  xc,
  input  wire logic signed [vpp_pkg::XCW-1:0]  yc,
  input  wire logic signed [vpp_pkg::RW-1:0]   w,
  output logic [vpp_pkg::NW-1:0]               nx,
  output logic [vpp_pkg::NW-1:0]               ny,
  output logic [vpp_pkg::BW-1:0]               den,
  output logic                                 on,
  output logic                                 behind
);
  import vpp_pkg::*;

  logic                  bh;
  logic signed [XCW-1:0] bw_s, xcc, ycc;
  logic [BW-1:0]         numx_nxt, numy_nxt, ax_nxt, bw_nxt;
  logic [BW-1:0]         numx_r, numy_r, ax_r, bw_r;
  logic                  bh0_r;
  logic [NW-1:0]         nx1_r, ny1_r, ah_r, wl_r;
  logic [BW-1:0]         den1_r;
  logic                  bh1_r;

  assign bh   = w[RW-1] | (w == '0);
  assign bw_s = XCW'(w) <<< PRJ_SH;

  always_comb begin
    xcc = xc;
    ycc = yc;
    if (xc < -bw_s) xcc = -bw_s;
    if (xc > bw_s)  xcc = bw_s;
    if (yc < -bw_s) ycc = -bw_s;
    if (yc > bw_s)  ycc = bw_s;
  end

  assign numx_nxt = bh ? '0 : BW'(xcc + bw_s);
  assign numy_nxt = bh ? '0 : BW'(bw_s - ycc);
  assign ax_nxt   = BW'(xcc[XCW-1] ? -xcc : xcc);
  assign bw_nxt   = BW'(bw_s);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      numx_r <= numx_nxt;
      numy_r <= numy_nxt;
      ax_r   <= ax_nxt;
      bw_r   <= bw_nxt;
      bh0_r  <= bh;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      nx1_r  <= NW'(numx_r) * NW'(width);
      ny1_r  <= NW'(numy_r) * NW'(height);
      ah_r   <= NW'(ax_r) * NW'(height);
      wl_r   <= NW'(bw_r) * NW'(width);
      // divisor 2W; unit divisor keeps the divider sane behind the camera
      den1_r <= bh0_r ? BW'(1) : (bw_r << 1);
      bh1_r  <= bh0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      nx     <= nx1_r;
      ny     <= ny1_r;
      den    <= den1_r;
      on     <= ~bh1_r & (ah_r <= wl_r);
      behind <= bh1_r;
    end
  end

endmodule
`default_nettype wire

/* sv/vpp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Quotient is known to fit QW bits. Depends on vpp_pkg.
`default_nettype none
module vpp_div (
  input  wire logic                       clk,
  input  wire logic [vpp_pkg::QW-1:0]     en,
  input  wire logic [vpp_pkg::NW-1:0]     num,
  input  wire logic [vpp_pkg::BW-1:0]     den,
  output logic [vpp_pkg::QW-1:0]          quo
);
  import vpp_pkg::*;

  logic [NW-1:0] rem_r [QW];
  logic [BW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [NW-1:0] rin, dsh;
    logic [BW-1:0] din;
    logic [QW-1:0] qin;
    if (i == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign din = den_r[i-1];
      assign qin = q_r[i-1];
    end
    assign dsh = NW'(din) << (QW - 1 - i);
    always_ff @(posedge clk) begin
      if (en[i]) begin
        den_r[i] <= din;
        if (rin >= dsh) begin
          rem_r[i] <= rin - dsh;
          q_r[i]   <= {qin[QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= rin;
          q_r[i]   <= {qin[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
`default_nettype wire

/* sv/vertex_perspective_projection.sv */
// Top level: vertex perspective projection pipeline.
// Depends on vpp_pkg, vpp_*_if, vpp_xform, vpp_clip, vpp_div.
//
//  port     dir  kind         carries
//  in_vtx   in   valid/ready  model_x, model_y, model_z (signed Q8.8)
//  out_pix  out  valid/ready  screen_x, screen_y, on_screen, behind_camera
//  cfg_wr   in   valid/ready  index, data (register write, always ready)
//
// One vertex per cycle sustained while out_pix.ready holds; 19 register stages
// lie between an accepted request and its valid result.
// Stages: 4 transform, 3 clip/aspect, 11 divider (one quotient bit each),
// 1 output register. The divider is the deepest part of the pipeline.
// Reset (rst_n low, synchronous) clears all stage valids and loads register defaults.
// Each stage holds while its successor is full and stalled, so bubbles
// collapse and requests are still taken while a result waits at the output.
`default_nettype none
module vertex_perspective_projection (
  input  wire logic clk,
  input  wire logic rst_n,
  vpp_in_if.sink    in_vtx,
  vpp_out_if.source out_pix,
  vpp_cfg_if.sink   cfg_wr
);
  import vpp_pkg::*;

  localparam int DIV0 = XF_ST + CL_ST;

  cfg_t cfg_r;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  logic signed [XCW-1:0] xc, yc;
  logic signed [RW-1:0]  w;
  logic [NW-1:0]         nx, ny;
  logic [BW-1:0]         den;
  logic                  on, behind;
  logic [QW-1:0]         qx, qy;

  // on_screen / behind_camera ride alongside the divider
  logic [1:0] flg_r [QW];

  logic [PXW-1:0] sx_r, sy_r;
  logic           on_r, bh_r;

  // config writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_COS:    cfg_r.cos_theta     <= $signed(cfg_wr.data);
        REG_SIN:    cfg_r.sin_theta     <= $signed(cfg_wr.data);
        REG_SCALE:  cfg_r.object_scale  <= cfg_wr.data;
        REG_DOFF:   cfg_r.depth_offset  <= $signed(cfg_wr.data);
        REG_XPS:    cfg_r.x_proj_scale  <= cfg_wr.data;
        REG_YPS:    cfg_r.y_proj_scale  <= cfg_wr.data;
        REG_WIDTH:  cfg_r.screen_width  <= cfg_wr.data[SZW-1:0];
        REG_HEIGHT: cfg_r.screen_height <= cfg_wr.data[SZW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // per-stage advance: a stage loads when it is empty or its successor moves
  for (genvar k = 0; k < NS; k++) begin : g_en
    if (k == NS - 1) begin : g_last
      assign en[k] = ~vld_r[k] | out_pix.ready;
    end else begin : g_mid
      assign en[k] = ~vld_r[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_vtx.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_vtx.ready = en[0];

  vpp_xform u_xform (
    .clk (clk),
    .en  (en[XF_ST-1:0]),
    .cfg (cfg_r),
    .x   (in_vtx.model_x),
    .y   (in_vtx.model_y),
    .z   (in_vtx.model_z),
    .xc  (xc),
    .yc  (yc),
    .w   (w)
  );

  vpp_clip u_clip (
    .clk    (clk),
    .en     (en[DIV0-1:XF_ST]),
    .width  (cfg_r.screen_width),
    .height (cfg_r.screen_height),
    .xc     (xc),
    .yc     (yc),
    .w      (w),
    .nx     (nx),
    .ny     (ny),
    .den    (den),
    .on     (on),
    .behind (behind)
  );

  vpp_div u_div_x (
    .clk (clk),
    .en  (en[DIV0+QW-1:DIV0]),
    .num (nx),
    .den (den),
    .quo (qx)
  );

  vpp_div u_div_y (
    .clk (clk),
    .en  (en[DIV0+QW-1:DIV0]),
    .num (ny),
    .den (den),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      flg_r[0] <= {behind, on};
    end
    for (int i = 1; i < QW; i++) begin
      if (en[DIV0+i]) begin
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  // output register: clamp to viewport and pixel field
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      sx_r <= pix_sat(qx, cfg_r.screen_width);
      sy_r <= pix_sat(qy, cfg_r.screen_height);
      on_r <= flg_r[QW-1][0];
      bh_r <= flg_r[QW-1][1];
    end
  end

  assign out_pix.valid         = vld_r[NS-1];
  assign out_pix.screen_x      = sx_r;
  assign out_pix.screen_y      = sy_r;
  assign out_pix.on_screen     = on_r;
  assign out_pix.behind_camera = bh_r;

  // a vertex behind the camera reports a zero pixel and off screen
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && out_pix.behind_camera |->
      out_pix.screen_x == '0 && out_pix.screen_y == '0 && !out_pix.on_screen)
    else $error("behind-camera result not zeroed");

  // an accepted request occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_vtx.valid && in_vtx.ready |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");

  // a full stall freezes every stage valid
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en[0] |=> $stable(vld_r))
    else $error("stage valids changed under full stall");

endmodule
`default_nettype wire

/* sim/tb_vertex_perspective_projection.sv */
// Self-checking testbench for vertex_perspective_projection.
// Depends on vpp_pkg, vpp_in_if, vpp_out_if, vpp_cfg_if and the block itself.
// A predictor checks every pixel result in order under random flow control.
`timescale 1ns / 100ps

module tb_vertex_perspective_projection;
  import vpp_pkg::*;

  typedef struct {
    logic [PXW-1:0] screen_x;
    logic [PXW-1:0] screen_y;
    logic           on_screen;
    logic           behind_camera;
  } pixel_t;

  // Holds its own copy of the projection registers and the pixels still owed.
  class pixel_scoreboard;
    longint cos_q, sin_q, scale_q, doff_q, xps_q, yps_q, width_q, height_q;
    pixel_t owed[$];
    int     errors;
    int     checked;
    int     behind_seen;
    int     onscreen_seen;

    function new();
      errors = 0;
      checked = 0;
      behind_seen = 0;
      onscreen_seen = 0;
      load_reg(REG_COS, CFG_RST.cos_theta);
      load_reg(REG_SIN, CFG_RST.sin_theta);
      load_reg(REG_SCALE, CFG_RST.object_scale);
      load_reg(REG_DOFF, CFG_RST.depth_offset);
      load_reg(REG_XPS, CFG_RST.x_proj_scale);
      load_reg(REG_YPS, CFG_RST.y_proj_scale);
      load_reg(REG_WIDTH, 16'(CFG_RST.screen_width));
      load_reg(REG_HEIGHT, 16'(CFG_RST.screen_height));
    endfunction

    function void load_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
      case (idx)
        REG_COS:    cos_q = longint'($signed(d));
        REG_SIN:    sin_q = longint'($signed(d));
        REG_SCALE:  scale_q = longint'(d);
        REG_DOFF:   doff_q = longint'($signed(d));
        REG_XPS:    xps_q = longint'(d);
        REG_YPS:    yps_q = longint'(d);
        REG_WIDTH:  width_q = longint'(d[SZW-1:0]);
        REG_HEIGHT: height_q = longint'(d[SZW-1:0]);
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // floor(num*size/den) clamped to size-1 and to the pixel field
    function logic [PXW-1:0] pixel_of(longint num, longint den, longint size);
      longint p;
      if (size <= 0) return '0;
      p = (num * size) / den;
      if (p > size - 1) p = size - 1;
      if (p > 1023) p = 1023;
      if (p < 0) p = 0;
      return PXW'(p);
    endfunction

    function pixel_t project(logic signed [CW-1:0] mx, logic signed [CW-1:0] my,
                             logic signed [CW-1:0] mz);
      pixel_t r;
      longint sx, sy, sz, xr, zr, w, big_w, xc, yc, ax;
      sx = longint'(mx) * scale_q;
      sy = longint'(my) * scale_q;
      sz = longint'(mz) * scale_q;
      xr = (sx * cos_q - sz * sin_q) >>> 14;
      zr = (sx * sin_q + sz * cos_q) >>> 14;
      w = -(zr + doff_q * 256);
      r = '{default: '0};
      if (w <= 0) begin
        r.behind_camera = 1'b1;
        return r;
      end
      big_w = w * 4096;
      xc = xr * xps_q;
      yc = sy * yps_q;
      if (xc < -big_w) xc = -big_w;
      if (xc > big_w) xc = big_w;
      if (yc < -big_w) yc = -big_w;
      if (yc > big_w) yc = big_w;
      ax = (xc < 0) ? -xc : xc;
      r.on_screen = (ax * height_q <= width_q * big_w);
      r.screen_x = pixel_of(xc + big_w, 2 * big_w, width_q);
      r.screen_y = pixel_of(big_w - yc, 2 * big_w, height_q);
      return r;
    endfunction

    function void note_vertex(logic signed [CW-1:0] mx, logic signed [CW-1:0] my,
                              logic signed [CW-1:0] mz);
      owed.insert(owed.size(), project(mx, my, mz));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d on=%0b behind=%0b", $realtime,
                 got.screen_x, got.screen_y, got.on_screen, got.behind_camera);
        errors++;
        return;
      end
      exp_p = owed.pop_front();
      checked++;
      if (exp_p.behind_camera) behind_seen++;
      if (exp_p.on_screen) onscreen_seen++;
      if (got.screen_x !== exp_p.screen_x) begin
        $display("%0t: screen_x expected %0d actual %0d", $realtime,
                 exp_p.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== exp_p.screen_y) begin
        $display("%0t: screen_y expected %0d actual %0d", $realtime,
                 exp_p.screen_y, got.screen_y);
        errors++;
      end
      if (got.on_screen !== exp_p.on_screen) begin
        $display("%0t: on_screen expected %0b actual %0b", $realtime,
                 exp_p.on_screen, got.on_screen);
        errors++;
      end
      if (got.behind_camera !== exp_p.behind_camera) begin
        $display("%0t: behind_camera expected %0b actual %0b", $realtime,
                 exp_p.behind_camera, got.behind_camera);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  vpp_in_if  in_vtx();
  vpp_out_if out_pix();
  vpp_cfg_if cfg_wr();

  vertex_perspective_projection u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_vtx.sink),
    .out_pix (out_pix.source),
    .cfg_wr  (cfg_wr.sink)
  );

  pixel_scoreboard board = new();
  int  cycles;
  int  sent;
  int  cfg_writes;
  bit  hold_req;      // asks the receiver for one long stall
  int  stall_mode;    // 0: always ready, 1: random, 2: mostly stalled

  localparam int LATENCY = 19;
  localparam int LIMIT   = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All inputs known from time zero.
  initial begin
    rst_n = 1'b0;
    in_vtx.valid = 1'b0;
    in_vtx.model_x = '0;
    in_vtx.model_y = '0;
    in_vtx.model_z = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    out_pix.ready = 1'b0;
  end

  // Monitor: sampled at the rising edge, before any flop of the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        board.load_reg(cfg_wr.index, cfg_wr.data);
      end
      if (in_vtx.valid && in_vtx.ready) begin
        board.note_vertex(in_vtx.model_x, in_vtx.model_y, in_vtx.model_z);
      end
      if (out_pix.valid && out_pix.ready) begin
        board.check_pixel('{out_pix.screen_x, out_pix.screen_y,
                            out_pix.on_screen, out_pix.behind_camera});
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pix.ready = 1'b0;
      end else begin
        case (stall_mode)
          0: out_pix.ready = 1'b1;
          1: out_pix.ready = ($urandom_range(0, 1) == 1);
          default: out_pix.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Timeout guard.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One vertex request; valid stays high until the handshake.
  task automatic send_vertex(logic signed [CW-1:0] mx, logic signed [CW-1:0] my,
                             logic signed [CW-1:0] mz);
    @(negedge clk);
    in_vtx.valid = 1'b1;
    in_vtx.model_x = mx;
    in_vtx.model_y = my;
    in_vtx.model_z = mz;
    do @(posedge clk); while (!in_vtx.ready);
    sent++;
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_vtx.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Block drained, then the pipeline latency again before touching registers.
  task automatic drain();
    idle_sender(1);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    @(negedge clk);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data = d;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic write_all(int c, int s, int sc, int dof, int xp, int yp, int wd, int ht);
    write_reg(REG_COS, CFG_DW'(c));
    write_reg(REG_SIN, CFG_DW'(s));
    write_reg(REG_SCALE, CFG_DW'(sc));
    write_reg(REG_DOFF, CFG_DW'(dof));
    write_reg(REG_XPS, CFG_DW'(xp));
    write_reg(REG_YPS, CFG_DW'(yp));
    write_reg(REG_WIDTH, CFG_DW'(wd));
    write_reg(REG_HEIGHT, CFG_DW'(ht));
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 1024;
      3:       return $urandom_range(1025, 2047);
      default: return $urandom_range(2, 1024);
    endcase
  endfunction

  task automatic random_config();
    int c, s, sc, dof;
    c = (($urandom_range(0, 4) == 0) ? 16384 : $urandom_range(0, 32768)) - 16384;
    s = $urandom_range(0, 32768) - 16384;
    case ($urandom_range(0, 5))
      0:       sc = $urandom_range(0, 65535);
      1:       sc = 0;
      default: sc = $urandom_range(64, 2048);
    endcase
    dof = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                      : -$urandom_range(256, 12800);
    write_all(c, s, sc, dof,
              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1000, 12000),
              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1000, 12000),
              pick_size(), pick_size());
    // unmapped indexes must leave the registers alone
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_HEIGHT + CFG_IW'($urandom_range(1, 8)), CFG_DW'($urandom()));
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    if ($urandom_range(0, 9) < 7) return CW'($urandom_range(0, 4096) - 2048);
    return CW'($urandom());
  endfunction

  // Bursts of random length with random gaps between them.
  task automatic random_burst_run(int n);
    int burst;
    while (n > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && n > 0; k++, n--)
        send_vertex(pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    hold_req = 1'b0;
    stall_mode = 0;
    sent = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset registers: origin, field extremes, w exactly zero and just positive.
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vertex(-16'sh8000, -16'sh8000, -16'sh8000);
    send_vertex(16'sh7FFF, -16'sh8000, 16'sd0);
    send_vertex(-16'sh8000, 16'sh7FFF, -16'sd5000);
    send_vertex(16'sd0, 16'sd0, 16'sd1280);     // w == 0: behind
    send_vertex(16'sd0, 16'sd0, 16'sd1279);     // smallest positive w here
    send_vertex(16'sd256, 16'sd256, 16'sd0);
    send_vertex(-16'sd256, -16'sd256, 16'sd1000);
    send_vertex(16'sd1200, 16'sd900, 16'sd1200); // clamped at +-W
    send_vertex(16'sd0, 16'sd0, 16'sd3000);      // behind
    drain();

    // Directed registers: trig extremes, zero viewport, big viewport.
    write_all(-16384, 16384, 65535, 32767, 65535, 65535, 0, 2047);
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(-16'sd100, 16'sd100, 16'sd50);
    send_vertex(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
    drain();
    write_all(0, -16384, 0, -32768, 0, 0, 1024, 0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vertex(16'sd1, -16'sd1, 16'sd0);
    drain();
    write_all(11585, 11585, 256, -2560, 4096, 4096, 2047, 1);
    send_vertex(16'sd128, -16'sd128, 16'sd64);
    send_vertex(-16'sd2000, 16'sd2000, -16'sd300);
    send_vertex(16'sd700, 16'sd10, 16'sd700);
    drain();
    write_reg(REG_HEIGHT + CFG_IW'(1), 16'hFFFF);

    // Back-to-back requests against a long output stall: the pipe fills and backs up.
    write_all(16384, 0, 1280, -6400, 5321, 7094, 320, 240);
    hold_req = 1'b1;
    for (int k = 0; k < 80; k++) send_vertex(pick_coord(), pick_coord(), pick_coord());
    drain();

    // Random phases under changing receiver behavior and register settings.
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      stall_mode = ph % 3;
      random_burst_run(130);
      drain();
    end

    idle_sender(1);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Run: %0d vertices sent, %0d pixels checked, %0d register writes",
             sent, board.checked, cfg_writes);
    $display("Run: %0d behind camera, %0d inside aspect bounds, %0d errors",
             board.behind_seen, board.onscreen_seen, board.errors);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
